FILE: src/assert_macros.svh
// Assertion macros shared by the voxel mask RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SEVM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SEVM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEVM_ASSERT(lbl, prop, msg)
`define SEVM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/sevm_pkg.sv
// Shared widths, codes and divider transfer types for the voxel mask unit.
// No dependencies.
package sevm_pkg;

    localparam int GRID_DEF   = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FUNC_W     = 2;
    localparam int COORD_W    = 24;
    localparam int RAD_W      = 16;
    localparam int SPC_W      = 16;
    localparam int CELL_W     = 6;
    localparam int REXCL_W    = RAD_W + 1;
    localparam int LIM_W      = 19;
    localparam int DIV_NUM_W  = 27;
    localparam int DIV_DEN_W  = SPC_W + 1;

    localparam logic [FUNC_W-1:0] FUNC_PLACE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SPACING_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS = 3'd7;

    localparam logic [SPC_W-1:0] SPACING_RST = 16'd4096;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [SPC_W-1:0] spc_eff(input logic [SPC_W-1:0] s);
        return (s == '0) ? SPC_W'(1) : s;
    endfunction

endpackage

FILE: src/sevm_div.sv
// Bit-serial signed by unsigned divider, quotient truncated toward zero.
// Depends on sevm_pkg.
module sevm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  sevm_pkg::div_req_t req,
    output sevm_pkg::div_rsp_t rsp
);
    import sevm_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 run_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W+1:0] trial;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.num[DIV_NUM_W-1];
            quo_reg <= req.num[DIV_NUM_W-1] ? DIV_NUM_W'(-req.num) : DIV_NUM_W'(req.num);
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (run_reg)
        begin
            if (trial[DIV_DEN_W+1])
            begin
                rem_reg <= shifted[DIV_DEN_W-1:0];
            end
            else
            begin
                rem_reg <= trial[DIV_DEN_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ~trial[DIV_DEN_W+1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

FILE: src/sphere_exclusion_voxel_mask_unit.sv
// Top level of the sphere exclusion voxel mask: config registers, sequencer, mask memory.
// Depends on sevm_pkg, sevm_div and assert_macros.svh.
//
// After reset the unit sweeps the mask memory clear, one cell per cycle, with
// busy high. Each item then holds busy until its single result strobe on done.
// A cell write passes through S_CA and S_CX before done strobes, a cell read
// through S_CA, S_CX and S_CR. Placing an atom runs six serial divisions
// (window half-size and home cell per axis, one quotient bit a cycle), then
// steps through S_P, S_D, S_M and, unless the plane or row is skipped, S_Q for
// each scanned z plane and y row, and through S_P, S_D, S_M, S_Q and S_C for
// each x cell, with one product multiplier shared by all axes.
// Results cannot be held off: take each strobe in the cycle it appears.
`include "assert_macros.svh"

module sphere_exclusion_voxel_mask_unit #(
    parameter int GRID_X = sevm_pkg::GRID_DEF,
    parameter int GRID_Y = sevm_pkg::GRID_DEF,
    parameter int GRID_Z = sevm_pkg::GRID_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sevm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sevm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [sevm_pkg::FUNC_W-1:0]           func,
    input  logic signed [sevm_pkg::COORD_W-1:0]   atom_x,
    input  logic signed [sevm_pkg::COORD_W-1:0]   atom_y,
    input  logic signed [sevm_pkg::COORD_W-1:0]   atom_z,
    input  logic [sevm_pkg::RAD_W-1:0]            atom_radius,
    input  logic [sevm_pkg::CELL_W-1:0]           cell_x,
    input  logic [sevm_pkg::CELL_W-1:0]           cell_y,
    input  logic [sevm_pkg::CELL_W-1:0]           cell_z,
    input  logic                                  cell_value,
    output logic                                  done,
    output logic                                  mask_bit
);
    import sevm_pkg::*;

    localparam int GMAX_XY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int GMAX    = (GMAX_XY > GRID_Z) ? GMAX_XY : GRID_Z;
    localparam int CW      = $clog2(GMAX + 1);
    localparam int NCELL   = GRID_X * GRID_Y * GRID_Z;
    localparam int AW      = $clog2(NCELL);
    localparam int PW      = CW + SPC_W;
    localparam int DW      = ((PW > COORD_W) ? PW : COORD_W) + 2;
    localparam int MAG_W   = REXCL_W + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int R2_W    = 2 * REXCL_W;
    localparam int RW      = DIV_NUM_W + 1;
    localparam int GRID_A [3] = '{GRID_X, GRID_Y, GRID_Z};

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DGO  = 4'd2;
    localparam logic [3:0] S_DWT  = 4'd3;
    localparam logic [3:0] S_RNG  = 4'd4;
    localparam logic [3:0] S_P    = 4'd5;
    localparam logic [3:0] S_D    = 4'd6;
    localparam logic [3:0] S_M    = 4'd7;
    localparam logic [3:0] S_Q    = 4'd8;
    localparam logic [3:0] S_C    = 4'd9;
    localparam logic [3:0] S_CA   = 4'd10;
    localparam logic [3:0] S_CX   = 4'd11;
    localparam logic [3:0] S_CR   = 4'd12;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [2:0] K_HOME = 3'd3;
    localparam logic [2:0] K_LAST = 3'd5;

    logic [3:0]                  state_reg;
    logic [AW-1:0]               clr_reg;
    logic [SPC_W-1:0]            spacing_reg [3];
    logic signed [COORD_W-1:0]   offset_reg [3];
    logic [RAD_W-1:0]            probe_reg;
    logic [RAD_W-1:0]            maxr_reg;
    logic [FUNC_W-1:0]           func_reg;
    logic signed [COORD_W-1:0]   atom_reg [3];
    logic [REXCL_W-1:0]          rexcl_reg;
    logic [CELL_W-1:0]           cell_reg [3];
    logic                        cval_reg;
    logic [2:0]                  k_reg;
    logic [LIM_W-1:0]            lim_reg [3];
    logic signed [DIV_NUM_W-1:0] home_reg [3];
    logic [CW-1:0]               lo_reg [3];
    logic [CW-1:0]               hi_reg [3];
    logic [CW-1:0]               idx_reg [3];
    logic [1:0]                  ax_reg;
    logic [PW-1:0]               prod_reg;
    logic signed [DW-1:0]        dist_reg;
    logic [MAG_W-1:0]            mag_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic [SQ_W-1:0]             dy2_reg;
    logic [SQ_W-1:0]             dz2_reg;
    logic [R2_W-1:0]             rexcl2_reg;
    logic [AW-1:0]               addr_reg;
    logic                        inside_reg;
    logic                        rd_data_reg;
    logic                        done_reg;
    logic                        mask_bit_reg;

    logic [SPC_W-1:0]            d_eff [3];
    div_req_t                    div_req;
    div_rsp_t                    div_rsp;
    logic [1:0]                  dax;
    logic [REXCL_W-1:0]          rmax;
    logic signed [DIV_NUM_W-1:0] a2;
    logic signed [DIV_NUM_W-1:0] o2;
    logic signed [DIV_NUM_W-1:0] dd;
    logic signed [RW-1:0]        lo_s [3];
    logic signed [RW-1:0]        hi_s [3];
    logic signed [RW-1:0]        lo_c [3];
    logic signed [RW-1:0]        hi_c [3];
    logic signed [RW-1:0]        g_s [3];
    logic                        empty_any;
    logic [CW-1:0]               cur_idx;
    logic [SPC_W-1:0]            cur_d;
    logic signed [COORD_W-1:0]   cur_off;
    logic signed [COORD_W-1:0]   cur_atom;
    logic signed [DW-1:0]        rex_s;
    logic [DW-1:0]               absd;
    logic [MAG_W-1:0]            mag;
    logic                        skip;
    logic                        hit;
    logic                        x_more;
    logic                        y_more;
    logic                        z_more;
    logic                        accept;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic                        mem_wdata;
    logic                        wr_state;
    logic                        mask_mem [NCELL];

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] ix,
                                                input logic [CW-1:0] iy,
                                                input logic [CW-1:0] iz);
        return AW'(ix) * AW'(GRID_Y * GRID_Z) + AW'(iy) * AW'(GRID_Z) + AW'(iz);
    endfunction

    sevm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            d_eff[a] = spc_eff(spacing_reg[a]);
        end
    end

    always_comb
    begin
        dax  = (k_reg >= K_HOME) ? 2'(k_reg - K_HOME) : k_reg[1:0];
        rmax = REXCL_W'(maxr_reg) + REXCL_W'(probe_reg);
        a2   = DIV_NUM_W'($signed({atom_reg[dax], 1'b0}));
        o2   = DIV_NUM_W'($signed({offset_reg[dax], 1'b0}));
        dd   = $signed(DIV_NUM_W'(d_eff[dax]));
        div_req.start = (state_reg == S_DGO);
        div_req.den   = {d_eff[dax], 1'b0};
        if (k_reg >= K_HOME)
        begin
            div_req.num = a2 + dd - o2;
        end
        else
        begin
            div_req.num = $signed(DIV_NUM_W'({rmax, 1'b0}) + DIV_NUM_W'({d_eff[dax], 1'b0})
                                  + DIV_NUM_W'(d_eff[dax]));
        end
    end

    always_comb
    begin
        empty_any = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            g_s[a]  = RW'(GRID_A[a]);
            lo_s[a] = RW'(home_reg[a]) - RW'(lim_reg[a]);
            hi_s[a] = RW'(home_reg[a]) + RW'(lim_reg[a]);
            lo_c[a] = (lo_s[a] < RW'(1)) ? RW'(1) : lo_s[a];
            hi_c[a] = (hi_s[a] > g_s[a]) ? g_s[a] : hi_s[a];
            if (lo_c[a] > hi_c[a])
            begin
                empty_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (ax_reg)
            AX_Y:
            begin
                cur_idx  = idx_reg[AX_Y];
                cur_d    = d_eff[AX_Y];
                cur_off  = offset_reg[AX_Y];
                cur_atom = atom_reg[AX_Y];
            end
            AX_Z:
            begin
                cur_idx  = idx_reg[AX_Z];
                cur_d    = d_eff[AX_Z];
                cur_off  = offset_reg[AX_Z];
                cur_atom = atom_reg[AX_Z];
            end
            default:
            begin
                cur_idx  = idx_reg[AX_X];
                cur_d    = d_eff[AX_X];
                cur_off  = offset_reg[AX_X];
                cur_atom = atom_reg[AX_X];
            end
        endcase
        rex_s  = DW'(rexcl_reg);
        absd   = dist_reg[DW-1] ? DW'(-dist_reg) : DW'(dist_reg);
        mag    = (absd > DW'(rexcl_reg)) ? MAG_W'(rexcl_reg) + MAG_W'(1) : absd[MAG_W-1:0];
        skip   = (ax_reg != AX_X) && (dist_reg > rex_s);
        hit    = (SUM_W'(sq_reg) + SUM_W'(dy2_reg) + SUM_W'(dz2_reg)) <= SUM_W'(rexcl2_reg);
        x_more = idx_reg[AX_X] < hi_reg[AX_X];
        y_more = idx_reg[AX_Y] < hi_reg[AX_Y];
        z_more = idx_reg[AX_Z] < hi_reg[AX_Z];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = 1'b1;
        case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 1'b0;
            end
            S_C:
            begin
                mem_we = hit;
            end
            S_CX:
            begin
                mem_we    = (func_reg == FUNC_WRITE) && inside_reg;
                mem_wdata = cval_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign wr_state = (state_reg == S_CLR) || (state_reg == S_C) || (state_reg == S_CX);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mask_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mask_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                spacing_reg[a] <= SPACING_RST;
                offset_reg[a]  <= '0;
            end
            probe_reg <= '0;
            maxr_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPACING_X:  spacing_reg[AX_X] <= cfg_data[SPC_W-1:0];
                REG_SPACING_Y:  spacing_reg[AX_Y] <= cfg_data[SPC_W-1:0];
                REG_SPACING_Z:  spacing_reg[AX_Z] <= cfg_data[SPC_W-1:0];
                REG_OFFSET_X:   offset_reg[AX_X]  <= $signed(cfg_data);
                REG_OFFSET_Y:   offset_reg[AX_Y]  <= $signed(cfg_data);
                REG_OFFSET_Z:   offset_reg[AX_Z]  <= $signed(cfg_data);
                REG_PROBE:      probe_reg         <= cfg_data[RAD_W-1:0];
                REG_MAX_RADIUS: maxr_reg          <= cfg_data[RAD_W-1:0];
                default:        probe_reg         <= probe_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            done_reg     <= 1'b0;
            mask_bit_reg <= 1'b0;
        end
        else
        begin
            done_reg     <= 1'b0;
            mask_bit_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(NCELL - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (func == FUNC_PLACE) ? S_DGO : S_CA;
                    end
                end
                S_DGO:
                begin
                    state_reg <= S_DWT;
                end
                S_DWT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= (k_reg == K_LAST) ? S_RNG : S_DGO;
                    end
                end
                S_RNG:
                begin
                    if (empty_any)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_P;
                    end
                end
                S_P:
                begin
                    state_reg <= S_D;
                end
                S_D:
                begin
                    state_reg <= S_M;
                end
                S_M:
                begin
                    if (!skip)
                    begin
                        state_reg <= S_Q;
                    end
                    else if ((ax_reg == AX_Y && y_more) || z_more)
                    begin
                        state_reg <= S_P;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_Q:
                begin
                    state_reg <= (ax_reg == AX_X) ? S_C : S_P;
                end
                S_C:
                begin
                    if (x_more || y_more || z_more)
                    begin
                        state_reg <= S_P;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_CA:
                begin
                    state_reg <= S_CX;
                end
                S_CX:
                begin
                    if (func_reg == FUNC_READ)
                    begin
                        state_reg <= S_CR;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_CR:
                begin
                    state_reg    <= S_IDLE;
                    done_reg     <= 1'b1;
                    mask_bit_reg <= inside_reg & rd_data_reg;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                func_reg       <= func;
                atom_reg[AX_X] <= atom_x;
                atom_reg[AX_Y] <= atom_y;
                atom_reg[AX_Z] <= atom_z;
                rexcl_reg      <= REXCL_W'(atom_radius) + REXCL_W'(probe_reg);
                cell_reg[AX_X] <= cell_x;
                cell_reg[AX_Y] <= cell_y;
                cell_reg[AX_Z] <= cell_z;
                cval_reg       <= cell_value;
                k_reg          <= '0;
            end
            S_DWT:
            begin
                if (div_rsp.done)
                begin
                    k_reg <= k_reg + 3'd1;
                    if (k_reg >= K_HOME)
                    begin
                        home_reg[dax] <= div_rsp.quo;
                    end
                    else
                    begin
                        lim_reg[dax] <= div_rsp.quo[LIM_W-1:0];
                    end
                end
            end
            S_RNG:
            begin
                rexcl2_reg <= R2_W'(rexcl_reg) * R2_W'(rexcl_reg);
                ax_reg     <= AX_Z;
                for (int a = 0; a < 3; a++)
                begin
                    lo_reg[a]  <= lo_c[a][CW-1:0];
                    hi_reg[a]  <= hi_c[a][CW-1:0];
                    idx_reg[a] <= lo_c[a][CW-1:0];
                end
            end
            S_P:
            begin
                prod_reg <= PW'(cur_idx) * PW'(cur_d);
            end
            S_D:
            begin
                dist_reg <= DW'(prod_reg) + DW'(cur_off) - DW'(cur_atom);
                addr_reg <= cell_addr(idx_reg[AX_X] - CW'(1), idx_reg[AX_Y] - CW'(1),
                                      idx_reg[AX_Z] - CW'(1));
            end
            S_M:
            begin
                mag_reg <= mag;
                if (skip)
                begin
                    if (ax_reg == AX_Y && y_more)
                    begin
                        idx_reg[AX_Y] <= idx_reg[AX_Y] + CW'(1);
                        idx_reg[AX_X] <= lo_reg[AX_X];
                    end
                    else
                    begin
                        ax_reg        <= AX_Z;
                        idx_reg[AX_Z] <= idx_reg[AX_Z] + CW'(1);
                        idx_reg[AX_Y] <= lo_reg[AX_Y];
                        idx_reg[AX_X] <= lo_reg[AX_X];
                    end
                end
            end
            S_Q:
            begin
                sq_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
                if (ax_reg == AX_Z)
                begin
                    ax_reg <= AX_Y;
                end
                else if (ax_reg == AX_Y)
                begin
                    ax_reg <= AX_X;
                end
            end
            S_C:
            begin
                if (x_more)
                begin
                    idx_reg[AX_X] <= idx_reg[AX_X] + CW'(1);
                end
                else if (y_more)
                begin
                    ax_reg        <= AX_Y;
                    idx_reg[AX_Y] <= idx_reg[AX_Y] + CW'(1);
                    idx_reg[AX_X] <= lo_reg[AX_X];
                end
                else
                begin
                    ax_reg        <= AX_Z;
                    idx_reg[AX_Z] <= idx_reg[AX_Z] + CW'(1);
                    idx_reg[AX_Y] <= lo_reg[AX_Y];
                    idx_reg[AX_X] <= lo_reg[AX_X];
                end
            end
            S_CA:
            begin
                inside_reg <= (cell_reg[AX_X] < GRID_X) && (cell_reg[AX_Y] < GRID_Y)
                              && (cell_reg[AX_Z] < GRID_Z);
                addr_reg   <= cell_addr(CW'(cell_reg[AX_X]), CW'(cell_reg[AX_Y]),
                                        CW'(cell_reg[AX_Z]));
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
        if (state_reg == S_Q && ax_reg == AX_Z)
        begin
            dz2_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        end
        if (state_reg == S_Q && ax_reg == AX_Y)
        begin
            dy2_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        end
    end

    assign done     = done_reg;
    assign mask_bit = mask_bit_reg;

    `SEVM_ASSERT(a_done_single, done |=> !done, "result strobe lasted more than one cycle")
    `SEVM_ASSERT_ALWAYS(a_mask_with_done, mask_bit |-> done, "mask_bit set without a result")
    `SEVM_ASSERT(a_write_legal, mem_we |-> wr_state, "mask written outside a write state")
    `SEVM_ASSERT(a_scan_lo, (state_reg == S_C) |-> (idx_reg[AX_X] >= lo_reg[AX_X]), "scan below window")
    `SEVM_ASSERT(a_scan_hi, (state_reg == S_C) |-> (idx_reg[AX_X] <= hi_reg[AX_X]), "scan above window")

endmodule

FILE: sim/sphere_exclusion_voxel_mask_unit_tb.sv
// Testbench for sphere_exclusion_voxel_mask_unit: places atoms, writes and reads cells,
// and checks every done strobe against an in-bench model of the mask and registers.
// Depends on sevm_pkg and the unit RTL.
module sphere_exclusion_voxel_mask_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sevm_pkg::*;

    localparam int G = 64;
    localparam int WATCHDOG = 6000000;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]         fn;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic [RAD_W-1:0]          rad;
        logic [CELL_W-1:0]         cx;
        logic [CELL_W-1:0]         cy;
        logic [CELL_W-1:0]         cz;
        logic                      val;
    } cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic [FUNC_W-1:0] func = '0;
    logic signed [COORD_W-1:0] atom_x = '0, atom_y = '0, atom_z = '0;
    logic [RAD_W-1:0] atom_radius = '0;
    logic [CELL_W-1:0] cell_x = '0, cell_y = '0, cell_z = '0;
    logic cell_value = 1'b0;
    logic done;
    logic mask_bit;

    sphere_exclusion_voxel_mask_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .func(func),
        .atom_x(atom_x), .atom_y(atom_y), .atom_z(atom_z), .atom_radius(atom_radius),
        .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z), .cell_value(cell_value),
        .done(done), .mask_bit(mask_bit)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bit   voxel [G*G*G];
    longint spc_r [3];
    longint off_r [3];
    longint probe_r, rmax_r;

    cmd_t   pending_cmds [$];
    bit     expected_bits [$];
    int     mismatches = 0;
    int     quiet_cycles = 0;
    bit     calm = 1'b0;

    function automatic longint eff_spc(int a);
        return spc_r[a] == 0 ? 1 : spc_r[a];
    endfunction

    function automatic void axis_window(int a, longint pos, output longint lo,
                                        output longint hi);
        longint d, lim, home;
        d = eff_spc(a);
        lim = (2 * (rmax_r + probe_r) + 3 * d) / (2 * d);
        home = (2 * pos + d - 2 * off_r[a]) / (2 * d);
        lo = home - lim;
        hi = home + lim;
        if (lo < 1) lo = 1;
        if (hi > G) hi = G;
    endfunction

    function automatic bit mask_outcome(cmd_t c);
        longint r, r2, xl, xh, yl, yh, zl, zh, dx, dy, dz;
        bit res;
        res = 1'b0;
        case (c.fn)
            FUNC_PLACE:
            begin
                r = longint'(c.rad) + probe_r;
                r2 = r * r;
                axis_window(0, longint'(c.ax), xl, xh);
                axis_window(1, longint'(c.ay), yl, yh);
                axis_window(2, longint'(c.az), zl, zh);
                for (longint z = zl; z <= zh; z++)
                begin
                    dz = z * eff_spc(2) + off_r[2] - longint'(c.az);
                    if (dz > r) continue;
                    for (longint y = yl; y <= yh; y++)
                    begin
                        dy = y * eff_spc(1) + off_r[1] - longint'(c.ay);
                        if (dy > r) continue;
                        for (longint x = xl; x <= xh; x++)
                        begin
                            dx = x * eff_spc(0) + off_r[0] - longint'(c.ax);
                            if (dx * dx + dy * dy + dz * dz <= r2)
                                voxel[((x - 1) * G + (y - 1)) * G + (z - 1)] = 1'b1;
                        end
                    end
                end
            end
            FUNC_READ:  res = voxel[(int'(c.cx) * G + int'(c.cy)) * G + int'(c.cz)];
            FUNC_WRITE: voxel[(int'(c.cx) * G + int'(c.cy)) * G + int'(c.cz)] = c.val;
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            if (pending_cmds.size() > 0)
                expected_bits.push_back(mask_outcome(pending_cmds.pop_front()));
        end
        if (rst_n && (!start || busy) && pending_cmds.size() > 0
            && (calm || $urandom_range(99) >= 36))
        begin
            start <= 1'b1;
            func <= pending_cmds[0].fn;
            atom_x <= pending_cmds[0].ax;
            atom_y <= pending_cmds[0].ay;
            atom_z <= pending_cmds[0].az;
            atom_radius <= pending_cmds[0].rad;
            cell_x <= pending_cmds[0].cx;
            cell_y <= pending_cmds[0].cy;
            cell_z <= pending_cmds[0].cz;
            cell_value <= pending_cmds[0].val;
        end
        else if (start && !busy)
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (done)
        begin
            if (expected_bits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected done, mask_bit %0b", mask_bit);
            end
            else
            begin
                automatic bit e = expected_bits.pop_front();
                if (mask_bit !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mask_bit mismatch: expected %0b actual %0b", e, mask_bit);
                end
            end
        end
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input longint v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SPACING_X, REG_SPACING_Y, REG_SPACING_Z: spc_r[idx] = v & 16'hFFFF;
            REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z:
                off_r[idx - 3] = longint'($signed(v[CFG_DATA_W-1:0]));
            REG_PROBE: probe_r = v & 16'hFFFF;
            default: rmax_r = v & 16'hFFFF;
        endcase
    endtask

    task automatic settle();
        while (pending_cmds.size() > 0 || expected_bits.size() > 0 || start)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic cmd_t cell_cmd(logic [FUNC_W-1:0] fn, int x, int y, int z, bit v);
        cmd_t c;
        c = '0;
        c.fn = fn;
        c.cx = CELL_W'(x); c.cy = CELL_W'(y); c.cz = CELL_W'(z); c.val = v;
        c.ax = COORD_W'($urandom); c.ay = COORD_W'($urandom); c.az = COORD_W'($urandom);
        c.rad = RAD_W'($urandom);
        return c;
    endfunction

    // atom near the grid, with radius up to rlim
    function automatic cmd_t atom_cmd(longint rlim);
        cmd_t c;
        c = '0;
        c.fn = FUNC_PLACE;
        c.ax = COORD_W'(off_r[0] + eff_spc(0) * longint'($urandom_range(66)) - eff_spc(0));
        c.ay = COORD_W'(off_r[1] + eff_spc(1) * longint'($urandom_range(66)) - eff_spc(1)
                        + $urandom_range(4095));
        c.az = COORD_W'(off_r[2] + eff_spc(2) * longint'($urandom_range(66)) - eff_spc(2));
        c.rad = RAD_W'($urandom_range(rlim));
        c.cx = CELL_W'($urandom); c.cy = CELL_W'($urandom); c.cz = CELL_W'($urandom);
        c.val = 1'($urandom);
        return c;
    endfunction

    function automatic cmd_t any_cmd(longint rlim);
        int k;
        cmd_t c;
        k = $urandom_range(99);
        if (k < 30) return atom_cmd(rlim);
        if (k < 65) return cell_cmd(FUNC_READ, $urandom_range(63), $urandom_range(63),
                                    $urandom_range(63), 1'b0);
        if (k < 90) return cell_cmd(FUNC_WRITE, $urandom_range(63), $urandom_range(63),
                                    $urandom_range(63), 1'($urandom));
        c = cell_cmd(FUNC_UNUSED, $urandom_range(63), 0, 0, 1'b0);
        return c;
    endfunction

    initial
    begin
        cmd_t c;
        for (int i = 0; i < 3; i++)
        begin
            spc_r[i] = 4096;
            off_r[i] = 0;
        end
        probe_r = 0;
        rmax_r = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, extremes of cells
        pending_cmds.push_back(cell_cmd(FUNC_READ, 0, 0, 0, 0));
        pending_cmds.push_back(cell_cmd(FUNC_WRITE, 63, 63, 63, 1));
        pending_cmds.push_back(cell_cmd(FUNC_READ, 63, 63, 63, 0));
        pending_cmds.push_back(cell_cmd(FUNC_WRITE, 63, 63, 63, 0));
        pending_cmds.push_back(cell_cmd(FUNC_READ, 63, 63, 63, 0));
        pending_cmds.push_back(cell_cmd(FUNC_UNUSED, 5, 5, 5, 1));
        c = cell_cmd(FUNC_PLACE, 0, 0, 0, 0);
        c.ax = 24'sd40960; c.ay = 24'sd40960; c.az = 24'sd40960; c.rad = 16'd8192;
        pending_cmds.push_back(c);
        pending_cmds.push_back(cell_cmd(FUNC_READ, 9, 9, 9, 0));
        pending_cmds.push_back(cell_cmd(FUNC_READ, 9, 9, 8, 0));
        c.ax = 24'sh7FFFFF; c.ay = 24'sh800000; c.az = 24'sh7FFFFF; c.rad = 16'hFFFF;
        pending_cmds.push_back(c);
        c.ax = 24'sh800000; c.ay = 24'sh7FFFFF; c.az = 24'sh800000; c.rad = 0;
        pending_cmds.push_back(c);
        c.ax = 24'sd4096; c.ay = 24'sd4096; c.az = 24'sd4096; c.rad = 16'd6000;
        pending_cmds.push_back(c);
        pending_cmds.push_back(cell_cmd(FUNC_READ, 0, 0, 0, 0));
        pending_cmds.push_back(cell_cmd(FUNC_READ, 1, 0, 0, 0));
        settle();

        // zero spacing, large window, extreme offsets
        set_reg(REG_SPACING_X, 0);
        set_reg(REG_SPACING_Y, 65535);
        set_reg(REG_SPACING_Z, 1);
        set_reg(REG_OFFSET_X, 24'sh7FFFFF);
        set_reg(REG_OFFSET_Y, -8388608);
        set_reg(REG_OFFSET_Z, 0);
        set_reg(REG_PROBE, 0);
        set_reg(REG_MAX_RADIUS, 2);
        c = cell_cmd(FUNC_PLACE, 0, 0, 0, 0);
        c.ax = 24'sh7FFFFF - 24'sd10; c.ay = -24'sd8388608 + 24'sd65535 * 3;
        c.az = 24'sd3; c.rad = 16'd2;
        pending_cmds.push_back(c);
        c.ax = 24'sh800000; c.rad = 16'hFFFF;
        pending_cmds.push_back(c);
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back(atom_cmd(3));
        pending_cmds.push_back(cell_cmd(FUNC_READ, 0, 2, 2, 0));
        settle();

        for (int phase = 0; phase < 4; phase++)
        begin
            longint s;
            s = (phase == 3) ? 65535 : 2048 + $urandom_range(6144);
            set_reg(REG_SPACING_X, s);
            set_reg(REG_SPACING_Y, 2048 + $urandom_range(6144));
            set_reg(REG_SPACING_Z, 2048 + $urandom_range(6144));
            set_reg(REG_OFFSET_X, -longint'($urandom_range(20000)));
            set_reg(REG_OFFSET_Y, longint'($urandom_range(20000)) - 10000);
            set_reg(REG_OFFSET_Z, -longint'($urandom_range(20000)));
            set_reg(REG_PROBE, (phase == 2) ? 65535 : $urandom_range(6000));
            set_reg(REG_MAX_RADIUS, (phase == 1) ? 65535 : $urandom_range(12000));
            calm = (phase == 2);
            for (int i = 0; i < 30; i++)
                pending_cmds.push_back(any_cmd((phase == 1) ? 65535 : 12000));
            settle();
        end

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
